>>> rtl/brct_pkg.sv
// Shared types, constants and helpers of the broadcast ring channel table.
package brct_pkg;

  // Default sizing of the table.
  localparam int unsigned DefSlots        = 16;
  localparam int unsigned DefRingDepth    = 64;
  localparam int unsigned DefMaxReceivers = 16;

  // Width of a message sequence number and of a cursor.
  localparam int unsigned SeqW = 32;

  typedef enum logic [2:0] {
    CMD_CREATE    = 3'd0,
    CMD_SUBSCRIBE = 3'd1,
    CMD_DROP_TX   = 3'd2,
    CMD_DROP_RX   = 3'd3,
    CMD_SEND      = 3'd4,
    CMD_RECV      = 3'd5,
    CMD_QUERY     = 3'd6,
    CMD_RESET_ALL = 3'd7
  } cmd_e;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_INVAL    = 4'd1,
    ST_NOTFOUND = 4'd2,
    ST_STALE    = 4'd3,
    ST_DISC     = 4'd4,
    ST_STATE    = 4'd5,
    ST_EXH      = 4'd6,
    ST_BLOCK    = 4'd7,
    ST_LAG      = 4'd8
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DIV,
    S_RAM,
    S_APPLY
  } state_e;

  // One command transaction.
  typedef struct packed {
    cmd_e        command;
    logic [3:0]  slot;
    logic [15:0] generation;
    logic [31:0] cursor;
    logic [15:0] capacity;
    logic [63:0] value;
  } item_t;

  // One result transaction.
  typedef struct packed {
    logic [3:0]  status;
    logic [3:0]  out_slot;
    logic [15:0] out_generation;
    logic [31:0] out_cursor;
    logic [63:0] rd_value;
    logic [4:0]  receivers;
    logic [31:0] total_sent;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic scan_start;
    logic scan_next;
    logic scan_append;
    logic div_start;
    logic div_step;
    logic ram_access;
    logic apply;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_e command;
    logic cap_bad;
    logic go_ram;
    logic scan_hit;
    logic scan_last;
    logic div_done;
  } dp_status_t;

  // Generation step that never lands on zero.
  function automatic logic [15:0] gen_step(input logic [15:0] g);
    logic [15:0] n;
    n = g + 16'd1;
    if (n == 16'd0) begin
      n = 16'd1;
    end
    return n;
  endfunction

endpackage

>>> rtl/brct_ram.sv
// Generic single-port RAM with registered read data.
module brct_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port share one address.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/brct_datapath.sv
// Datapath: channel table, slot scan, ring index divider, message RAM and result.
module brct_datapath #(
  parameter int unsigned SLOTS         = 16,
  parameter int unsigned RING_DEPTH    = 64,
  parameter int unsigned MAX_RECEIVERS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  brct_pkg::item_t     item_i,
  input  brct_pkg::ctrl_cmd_t ctrl_i,
  output brct_pkg::dp_status_t stat_o,
  output brct_pkg::result_t   result_o,
  output logic                done_o
);

  import brct_pkg::*;

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned UW = $clog2(SLOTS + 1);
  localparam int unsigned CW = $clog2(RING_DEPTH + 1);
  localparam int unsigned RW = $clog2(MAX_RECEIVERS + 1);
  localparam int unsigned MD = SLOTS * RING_DEPTH;
  localparam int unsigned AW = (MD > 1) ? $clog2(MD) : 1;
  localparam int unsigned CntW = $clog2(SeqW + 1);

  // Latched command and table state.
  item_t           item_q;
  logic [SW-1:0]   addr_q;
  logic [UW-1:0]   used_q;
  logic            exh_q, app_q;
  logic [15:0]     gen_q   [SLOTS];
  logic            alive_q [SLOTS];
  logic [CW-1:0]   cap_q   [SLOTS];
  logic [31:0]     wc_q    [SLOTS];
  logic [RW-1:0]   rx_q    [SLOTS];

  // Divider state.
  logic [CW-1:0]   rem_q;
  logic [31:0]     div_q;
  logic [CntW-1:0] cnt_q;

  result_t         result_q;
  logic            done_q;
  logic [63:0]     rdata;

  // Entry selected by the current address.
  logic [15:0]   e_gen;
  logic          e_alive;
  logic [CW-1:0] e_cap, e_ecap;
  logic [31:0]   e_wc, oldest;
  logic [RW-1:0] e_rx;
  logic [8:0]    slot_ext, addr_ext, used_ext;
  logic          in_range, hdl_ok, cap_bad, lag, cur_ahead;
  status_e       hdl_st, st;
  logic [CW:0]   shifted;
  logic [AW-1:0] ram_addr;
  result_t       res_d;

  assign e_gen   = gen_q[addr_q];
  assign e_alive = alive_q[addr_q];
  assign e_cap   = cap_q[addr_q];
  assign e_wc    = wc_q[addr_q];
  assign e_rx    = rx_q[addr_q];
  assign e_ecap  = ((e_cap == '0) || (32'(e_cap) > RING_DEPTH)) ? CW'(RING_DEPTH) : e_cap;

  // Handle check against the latched slot and generation.
  assign slot_ext = 9'(item_q.slot);
  assign addr_ext = 9'(addr_q);
  assign used_ext = 9'(used_q);
  assign in_range = (slot_ext < used_ext) && (slot_ext < 9'(SLOTS));
  always_comb begin
    if (!in_range) begin
      hdl_st = ST_NOTFOUND;
    end else if (e_gen != item_q.generation) begin
      hdl_st = ST_STALE;
    end else begin
      hdl_st = ST_OK;
    end
  end
  assign hdl_ok = (hdl_st == ST_OK);

  assign cap_bad   = (item_q.capacity == 16'd0) || (32'(item_q.capacity) > RING_DEPTH);
  assign cur_ahead = (item_q.cursor >= e_wc);
  assign oldest    = (e_wc > 32'(e_cap)) ? (e_wc - 32'(e_cap)) : 32'd0;
  assign lag       = (item_q.cursor < oldest);

  // Status toward the controller.
  always_comb begin
    stat_o.command   = item_q.command;
    stat_o.cap_bad   = cap_bad;
    stat_o.go_ram    = hdl_ok && (((item_q.command == CMD_SEND) && e_alive) ||
                       ((item_q.command == CMD_RECV) && !cur_ahead && !lag));
    stat_o.scan_hit  = (addr_ext < used_ext) && !e_alive && (e_rx == '0);
    stat_o.scan_last = ((addr_ext + 9'd1) >= used_ext);
    stat_o.div_done  = (cnt_q == CntW'(SeqW));
  end

  // One restoring step of the sequence modulo the ring capacity.
  assign shifted = {rem_q, div_q[31]};

  // Message RAM address: slot base plus ring position.
  assign ram_addr = AW'(32'(addr_q) * 32'(RING_DEPTH) + 32'(rem_q));

  brct_ram #(
    .WIDTH(64),
    .DEPTH(MD)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ctrl_i.ram_access && (item_q.command == CMD_SEND)),
    .re_i   (ctrl_i.ram_access && (item_q.command == CMD_RECV)),
    .addr_i (ram_addr),
    .wdata_i(item_q.value),
    .rdata_o(rdata)
  );

  // Result of the command at the apply step.
  always_comb begin
    res_d = '0;
    st    = ST_OK;
    unique case (item_q.command)
      CMD_CREATE: begin
        if (cap_bad) begin
          st = ST_INVAL;
        end else if (exh_q) begin
          st = ST_EXH;
        end else begin
          res_d.out_slot       = 4'(addr_q);
          res_d.out_generation = gen_step(e_gen);
        end
      end
      CMD_SUBSCRIBE: begin
        st = hdl_st;
        if (hdl_ok) begin
          if (!e_alive) begin
            st = ST_DISC;
          end else if (32'(e_rx) >= MAX_RECEIVERS) begin
            st = ST_EXH;
          end else begin
            res_d.out_slot       = item_q.slot;
            res_d.out_generation = e_gen;
            res_d.out_cursor     = e_wc;
          end
        end
      end
      CMD_SEND: begin
        st = hdl_st;
        if (hdl_ok && !e_alive) begin
          st = ST_STATE;
        end
      end
      CMD_RECV: begin
        st = hdl_st;
        res_d.out_cursor = item_q.cursor;
        if (hdl_ok) begin
          if (cur_ahead) begin
            st = e_alive ? ST_BLOCK : ST_DISC;
          end else if (lag) begin
            st = ST_LAG;
            res_d.out_cursor = oldest;
          end else begin
            res_d.rd_value   = rdata;
            res_d.out_cursor = item_q.cursor + 32'd1;
          end
        end
      end
      CMD_QUERY: begin
        st = hdl_st;
        if (hdl_ok) begin
          res_d.receivers  = 5'(e_rx);
          res_d.total_sent = e_wc;
        end
      end
      default: begin
        st = ST_OK;
      end
    endcase
    res_d.status = st;
  end

  // Payload registers: latched item, divider data and result.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) begin
      item_q <= item_i;
    end
    if (ctrl_i.div_start) begin
      div_q <= (item_q.command == CMD_SEND) ? e_wc : item_q.cursor;
      rem_q <= '0;
    end else if (ctrl_i.div_step) begin
      div_q <= {div_q[30:0], 1'b0};
      rem_q <= (shifted >= (CW+1)'(e_ecap)) ? CW'(shifted - (CW+1)'(e_ecap)) : CW'(shifted);
    end
    if (ctrl_i.apply) begin
      result_q <= res_d;
    end
  end

  // Control registers and the channel table.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
      used_q <= '0;
      exh_q  <= 1'b0;
      app_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        gen_q[i]   <= '0;
        alive_q[i] <= 1'b0;
        cap_q[i]   <= '0;
        wc_q[i]    <= '0;
        rx_q[i]    <= '0;
      end
    end else begin
      done_q <= ctrl_i.apply;

      // Address register for handle and scan accesses.
      if (ctrl_i.latch) begin
        addr_q <= SW'(item_i.slot);
        exh_q  <= 1'b0;
        app_q  <= 1'b0;
      end else if (ctrl_i.scan_start) begin
        addr_q <= '0;
      end else if (ctrl_i.scan_next) begin
        addr_q <= addr_q + SW'(1);
      end else if (ctrl_i.scan_append) begin
        if (used_ext < 9'(SLOTS)) begin
          addr_q <= used_q[SW-1:0];
          app_q  <= 1'b1;
        end else begin
          exh_q  <= 1'b1;
        end
      end

      // Divider step counter.
      if (ctrl_i.div_start) begin
        cnt_q <= '0;
      end else if (ctrl_i.div_step) begin
        cnt_q <= cnt_q + CntW'(1);
      end

      // Table update of the finished command.
      if (ctrl_i.apply) begin
        unique case (item_q.command)
          CMD_CREATE: begin
            if (!cap_bad && !exh_q) begin
              gen_q[addr_q]   <= gen_step(e_gen);
              alive_q[addr_q] <= 1'b1;
              cap_q[addr_q]   <= CW'(item_q.capacity);
              wc_q[addr_q]    <= '0;
              rx_q[addr_q]    <= RW'(1);
              if (app_q) begin
                used_q <= used_q + UW'(1);
              end
            end
          end
          CMD_SUBSCRIBE: begin
            if (hdl_ok && e_alive && (32'(e_rx) < MAX_RECEIVERS)) begin
              rx_q[addr_q] <= e_rx + RW'(1);
            end
          end
          CMD_DROP_TX: begin
            if (hdl_ok) begin
              alive_q[addr_q] <= 1'b0;
            end
          end
          CMD_DROP_RX: begin
            if (hdl_ok && (e_rx != '0)) begin
              rx_q[addr_q] <= e_rx - RW'(1);
            end
          end
          CMD_SEND: begin
            if (hdl_ok && e_alive) begin
              wc_q[addr_q] <= e_wc + 32'd1;
            end
          end
          CMD_RESET_ALL: begin
            for (int i = 0; i < SLOTS; i++) begin
              gen_q[i]   <= gen_step(gen_q[i]);
              alive_q[i] <= 1'b0;
              cap_q[i]   <= '0;
              wc_q[i]    <= '0;
              rx_q[i]    <= '0;
            end
            used_q <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign result_o = result_q;
  assign done_o   = done_q;

endmodule

>>> rtl/brct_ctrl.sv
// Controller state machine that sequences each command through the datapath.
module brct_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  brct_pkg::dp_status_t stat_i,
  output brct_pkg::ctrl_cmd_t  ctrl_o,
  output logic                 busy_o
);

  import brct_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ctrl_o.latch = 1'b1;
          state_d      = S_CHECK;
        end
      end
      S_CHECK: begin
        unique case (stat_i.command)
          CMD_CREATE: begin
            if (stat_i.cap_bad) begin
              state_d = S_APPLY;
            end else begin
              ctrl_o.scan_start = 1'b1;
              state_d           = S_SCAN;
            end
          end
          CMD_SEND, CMD_RECV: begin
            if (stat_i.go_ram) begin
              ctrl_o.div_start = 1'b1;
              state_d          = S_DIV;
            end else begin
              state_d = S_APPLY;
            end
          end
          default: begin
            state_d = S_APPLY;
          end
        endcase
      end
      S_SCAN: begin
        if (stat_i.scan_hit) begin
          state_d = S_APPLY;
        end else if (stat_i.scan_last) begin
          ctrl_o.scan_append = 1'b1;
          state_d            = S_APPLY;
        end else begin
          ctrl_o.scan_next = 1'b1;
        end
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          state_d = S_RAM;
        end else begin
          ctrl_o.div_step = 1'b1;
        end
      end
      S_RAM: begin
        ctrl_o.ram_access = 1'b1;
        state_d           = S_APPLY;
      end
      S_APPLY: begin
        ctrl_o.apply = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

>>> rtl/broadcast_ring_channel_table.sv
// Query, drops, reset all and rejected commands pass from the check straight to the apply step;
// create first runs the free slot scan, one step per slot examined.
// Send and a successful try receive run the bit-serial ring modulo, then the message RAM
// port access, before apply. One command at a time; busy is high until done_o.
// Reset clears the table asynchronously and needs no clearing pass; message RAM is
// left unset. The receiver cannot stall, so done_o is high for exactly one cycle.
module broadcast_ring_channel_table #(
  parameter int unsigned SLOTS         = brct_pkg::DefSlots,
  parameter int unsigned RING_DEPTH    = brct_pkg::DefRingDepth,
  parameter int unsigned MAX_RECEIVERS = brct_pkg::DefMaxReceivers
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  brct_pkg::item_t   item_i,
  output logic              done_o,
  output brct_pkg::result_t result_o
);

  import brct_pkg::*;

  ctrl_cmd_t  ctrl;
  dp_status_t stat;

  // Command sequencer.
  brct_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy_o (busy)
  );

  // Table, divider and message storage.
  brct_datapath #(
    .SLOTS        (SLOTS),
    .RING_DEPTH   (RING_DEPTH),
    .MAX_RECEIVERS(MAX_RECEIVERS)
  ) u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_i),
    .ctrl_i  (ctrl),
    .stat_o  (stat),
    .result_o(result_o),
    .done_o  (done_o)
  );

endmodule
